[sv/lidar_frame_parser_offset_defines.svh]
// Assertion macros for the rangefinder frame parser.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef LIDAR_FRAME_PARSER_OFFSET_DEFINES_SVH
`define LIDAR_FRAME_PARSER_OFFSET_DEFINES_SVH

`ifndef ASSERT_OFF
`define LFPO_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lfpo: implication check failed");
`define LFPO_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lfpo: next-cycle check failed");
`else
`define LFPO_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define LFPO_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[sv/lfpo_pkg.sv]
// Shared constants and types for the rangefinder frame parser.
// Depends on nothing.
package lfpo_pkg;

  localparam int unsigned FRAME_LENGTH = 9;
  localparam int unsigned POS_W        = 4;
  localparam int unsigned OFFSET_W     = 10;
  localparam int unsigned DIST_W       = 16;

  localparam logic [7:0]        HDR_BYTE      = 8'h59;
  localparam logic [DIST_W-1:0] REJECT_VALUE  = 16'hFFFF;
  localparam logic [DIST_W-1:0] WIN_LOW_RST   = 16'd2;
  localparam logic [DIST_W-1:0] WIN_HIGH_RST  = 16'd4500;
  localparam logic [POS_W-1:0]  POS_HUNT      = 4'd0;
  localparam logic [POS_W-1:0]  POS_HDR2      = 4'd1;
  localparam logic [POS_W-1:0]  POS_FIRST_FLD = 4'd2;
  localparam logic [POS_W-1:0]  POS_LAST_FLD  = 4'd5;
  localparam logic [POS_W-1:0]  POS_CHECKSUM  = POS_W'(FRAME_LENGTH - 1);

  localparam logic [1:0] REG_OFFSET   = 2'd0;
  localparam logic [1:0] REG_WIN_LOW  = 2'd1;
  localparam logic [1:0] REG_WIN_HIGH = 2'd2;

  typedef struct packed {
    logic [DIST_W-1:0] raw;
    logic [DIST_W-1:0] strength;
  } frame_t;

  typedef struct packed {
    logic signed [OFFSET_W-1:0] offset;
    logic [DIST_W-1:0]          win_low;
    logic [DIST_W-1:0]          win_high;
  } cfg_t;

endpackage

[sv/lidar_frame_parser_offset.sv]
// Rangefinder 9-byte frame parser with distance offset and acceptance window.
// Latency: a result is valid the cycle after its checksum byte is taken.
// Throughput: one byte per cycle; in_ready_o drops only while a result waits.
// Reset: asynchronous, active low; hunts the first header, held distance 0,
// offset 0, window 2 to 4500. Depends on lfpo_pkg, lfpo_sync, lfpo_filter.
`include "lidar_frame_parser_offset_defines.svh"

module lidar_frame_parser_offset import lfpo_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DIST_W-1:0] raw_distance_o,
  output logic [DIST_W-1:0] signal_strength_o,
  output logic [DIST_W-1:0] held_distance_o,
  output logic              accepted_o,
  output logic              differs_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [DIST_W-1:0] cfg_data_i
);

  cfg_t   cfg_q;
  logic   byte_take;
  logic   frame_valid;
  frame_t frame;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_o || out_ready_i;
  assign byte_take   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset   <= '0;
      cfg_q.win_low  <= WIN_LOW_RST;
      cfg_q.win_high <= WIN_HIGH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_OFFSET:   cfg_q.offset   <= $signed(cfg_data_i[OFFSET_W-1:0]);
        REG_WIN_LOW:  cfg_q.win_low  <= cfg_data_i;
        REG_WIN_HIGH: cfg_q.win_high <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lfpo_sync u_sync (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_valid_i  (byte_take),
    .byte_i        (rx_byte_i),
    .frame_valid_o (frame_valid),
    .frame_o       (frame)
  );

  lfpo_filter u_filter (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .frame_valid_i     (frame_valid),
    .frame_i           (frame),
    .cfg_i             (cfg_q),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .raw_distance_o    (raw_distance_o),
    .signal_strength_o (signal_strength_o),
    .held_distance_o   (held_distance_o),
    .accepted_o        (accepted_o),
    .differs_o         (differs_o)
  );

  `LFPO_ASSERT_IMPL(a_acc_needs_diff, clk_i, rst_ni, out_valid_o && accepted_o, differs_o)
  `LFPO_ASSERT_IMPL(a_same_keeps_held, clk_i, rst_ni, out_valid_o && !differs_o,
                    held_distance_o == raw_distance_o)
  `LFPO_ASSERT_NEXT(a_result_from_byte, clk_i, rst_ni, !byte_take, !$rose(out_valid_o))

endmodule

[sv/lfpo_sync.sv]
// Byte-level frame sync: header hunt, running checksum and field capture.
// Depends on lfpo_pkg.
module lfpo_sync import lfpo_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  output logic       frame_valid_o,
  output frame_t     frame_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       fbytes_q [4];
  logic             fld_we;
  logic [1:0]       fld_idx;

  always_comb begin
    pos_d         = pos_q;
    sum_d         = sum_q;
    fld_we        = 1'b0;
    fld_idx       = pos_q[1:0] - 2'd2;
    frame_valid_o = 1'b0;
    if (byte_valid_i) begin
      if (pos_q == POS_HUNT || pos_q > POS_CHECKSUM) begin
        if (byte_i == HDR_BYTE) begin
          sum_d = byte_i;
          pos_d = POS_HDR2;
        end else begin
          pos_d = POS_HUNT;
        end
      end else if (pos_q == POS_HDR2) begin
        if (byte_i == HDR_BYTE) begin
          sum_d = sum_q + byte_i;
          pos_d = POS_FIRST_FLD;
        end else begin
          pos_d = POS_HUNT;
        end
      end else if (pos_q < POS_CHECKSUM) begin
        fld_we = (pos_q <= POS_LAST_FLD);
        sum_d  = sum_q + byte_i;
        pos_d  = pos_q + 4'd1;
      end else begin
        pos_d         = POS_HUNT;
        frame_valid_o = (byte_i == sum_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_HUNT;
      sum_q <= 8'd0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fld_we) begin
      fbytes_q[fld_idx] <= byte_i;
    end
  end

  assign frame_o.raw      = {fbytes_q[1], fbytes_q[0]};
  assign frame_o.strength = {fbytes_q[3], fbytes_q[2]};

endmodule

[sv/lfpo_filter.sv]
// Offset correction, window check, held distance and result register.
// Depends on lfpo_pkg.
module lfpo_filter import lfpo_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              frame_valid_i,
  input  frame_t            frame_i,
  input  cfg_t              cfg_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [DIST_W-1:0] raw_distance_o,
  output logic [DIST_W-1:0] signal_strength_o,
  output logic [DIST_W-1:0] held_distance_o,
  output logic              accepted_o,
  output logic              differs_o
);

  logic [DIST_W-1:0]        held_q, held_d;
  logic                     valid_q, valid_d;
  logic [DIST_W-1:0]        raw_q, str_q, hout_q;
  logic                     acc_q, diff_q;
  logic signed [DIST_W+1:0] corr;
  logic                     diff, in_win, acc;

  always_comb begin
    diff   = (frame_i.raw != held_q);
    corr   = $signed({2'b00, frame_i.raw}) + (DIST_W+2)'(cfg_i.offset);
    in_win = !corr[DIST_W+1]
             && (corr[DIST_W:0] >= {1'b0, cfg_i.win_low})
             && (corr[DIST_W:0] <= {1'b0, cfg_i.win_high})
             && (corr[DIST_W:0] != {1'b0, REJECT_VALUE});
    acc    = diff && in_win;
    held_d = held_q;
    if (frame_valid_i && acc) begin
      held_d = corr[DIST_W-1:0];
    end
    valid_d = frame_valid_i || (valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      held_q  <= held_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_valid_i) begin
      raw_q  <= frame_i.raw;
      str_q  <= frame_i.strength;
      hout_q <= held_d;
      acc_q  <= acc;
      diff_q <= diff;
    end
  end

  assign out_valid_o       = valid_q;
  assign raw_distance_o    = raw_q;
  assign signal_strength_o = str_q;
  assign held_distance_o   = hout_q;
  assign accepted_o        = acc_q;
  assign differs_o         = diff_q;

endmodule

[test/tb_top.sv]
// Self-checking testbench for lidar_frame_parser_offset: random and directed byte streams
// are checked, reading by reading, against a frame predictor held in a small scoreboard class.
// Depends on lfpo_pkg and the parser RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lfpo_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_BYTES    = 220;
  localparam int unsigned TOTAL_BYTES    = 1750;

  typedef struct packed {
    logic [DIST_W-1:0] raw;
    logic [DIST_W-1:0] strength;
    logic [DIST_W-1:0] held;
    logic              acc;
    logic              diff;
  } reading_t;

  class frame_scoreboard;
    logic [POS_W-1:0]           pos;
    logic [7:0]                 sum;
    logic [7:0]                 field_bytes [4];
    logic [DIST_W-1:0]          held;
    logic signed [OFFSET_W-1:0] offset;
    logic [DIST_W-1:0]          win_low;
    logic [DIST_W-1:0]          win_high;
    reading_t                   expected_readings [$];
    int unsigned                mismatches;
    int unsigned                readings_seen;

    function new();
      pos           = POS_HUNT;
      sum           = '0;
      held          = '0;
      offset        = '0;
      win_low       = WIN_LOW_RST;
      win_high      = WIN_HIGH_RST;
      mismatches    = 0;
      readings_seen = 0;
      foreach (field_bytes[i]) field_bytes[i] = '0;
    endfunction

    function void apply_register(logic [1:0] idx, logic [DIST_W-1:0] data);
      case (idx)
        REG_OFFSET:   offset = data[OFFSET_W-1:0];
        REG_WIN_LOW:  win_low = data;
        REG_WIN_HIGH: win_high = data;
        default: ;
      endcase
    endfunction

    function void note_rx_byte(logic [7:0] b);
      reading_t r;
      int       corr;
      if (pos == POS_HUNT || pos >= FRAME_LENGTH) begin
        if (b == HDR_BYTE) begin
          sum = b;
          pos = POS_HDR2;
        end else begin
          pos = POS_HUNT;
        end
      end else if (pos == POS_HDR2) begin
        if (b == HDR_BYTE) begin
          sum = sum + b;
          pos = POS_FIRST_FLD;
        end else begin
          pos = POS_HUNT;
        end
      end else if (pos < POS_CHECKSUM) begin
        if (pos <= POS_LAST_FLD) field_bytes[2'(pos - POS_FIRST_FLD)] = b;
        sum = sum + b;
        pos = pos + 4'd1;
      end else begin
        pos = POS_HUNT;
        if (b == sum) begin
          r.raw      = {field_bytes[1], field_bytes[0]};
          r.strength = {field_bytes[3], field_bytes[2]};
          r.diff     = (r.raw != held);
          r.acc      = 1'b0;
          if (r.diff) begin
            corr = int'(r.raw) + int'(offset);
            if (corr >= int'(win_low) && corr <= int'(win_high) &&
                corr != int'(REJECT_VALUE)) begin
              held  = corr[DIST_W-1:0];
              r.acc = 1'b1;
            end
          end
          r.held = held;
          expected_readings.push_back(r);
        end
      end
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      bit       bad;
      readings_seen++;
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reading %0d with none expected: raw %h str %h held %h acc %b diff %b",
                   readings_seen, got.raw, got.strength, got.held, got.acc, got.diff);
        return;
      end
      want = expected_readings.pop_front();
      bad = (got.raw !== want.raw) || (got.strength !== want.strength) ||
            (got.held !== want.held) || (got.acc !== want.acc) || (got.diff !== want.diff);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("reading %0d mismatch: expected raw %h str %h held %h acc %b diff %b",
                   readings_seen, want.raw, want.strength, want.held, want.acc, want.diff);
          $display("                        actual raw %h str %h held %h acc %b diff %b",
                   got.raw, got.strength, got.held, got.acc, got.diff);
        end
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        rx_byte_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [DIST_W-1:0] raw_distance_o;
  logic [DIST_W-1:0] signal_strength_o;
  logic [DIST_W-1:0] held_distance_o;
  logic              accepted_o;
  logic              differs_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i;
  logic [DIST_W-1:0] cfg_data_i;

  frame_scoreboard sb = new();
  int unsigned     bytes_sent;
  int unsigned     idle_cycles;
  int unsigned     stall_left;
  bit              sender_gaps;
  bit              receiver_stalls;

  lidar_frame_parser_offset u_dut (.*);

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [DIST_W-1:0] pick_raw();
    int target;
    case ($urandom_range(9))
      0: target = int'(sb.held);
      1: target = int'(sb.win_low) - int'(sb.offset) + int'($urandom_range(2)) - 1;
      2: target = int'(sb.win_high) - int'(sb.offset) + int'($urandom_range(2)) - 1;
      3: target = int'(REJECT_VALUE) - int'(sb.offset);
      4: target = $urandom_range(1) ? 0 : int'(REJECT_VALUE);
      5: target = $urandom_range(600);
      6: target = $urandom_range(4600);
      default: target = $urandom_range(65535);
    endcase
    return target[DIST_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] pick_strength();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return DIST_W'($urandom_range(65535));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [DIST_W-1:0] raw, input logic [DIST_W-1:0] strength,
                            input logic [DIST_W-1:0] tail, input bit bad_sum);
    logic [7:0] f [9];
    logic [7:0] s;
    f = '{HDR_BYTE, HDR_BYTE, raw[7:0], raw[15:8], strength[7:0], strength[15:8],
          tail[7:0], tail[15:8], 8'h00};
    s = '0;
    for (int i = 0; i < 8; i++) s = s + f[i];
    f[8] = bad_sum ? s + 8'($urandom_range(255, 1)) : s;
    foreach (f[i]) send_byte(f[i]);
  endtask

  // drop valid and hold until every expected reading has come back
  task automatic settle_input();
    in_valid_i <= 1'b0;
    while (sb.expected_readings.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DIST_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.apply_register(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input int off, input int lo, input int hi);
    write_reg(REG_OFFSET, 16'(off));
    write_reg(REG_WIN_LOW, 16'(lo));
    write_reg(REG_WIN_HIGH, 16'(hi));
  endtask

  task automatic random_traffic(input int unsigned count);
    int unsigned start;
    int unsigned r;
    start = bytes_sent;
    while (bytes_sent - start < count) begin
      r = $urandom_range(99);
      if (r < 75) begin
        send_frame(pick_raw(), pick_strength(), DIST_W'($urandom_range(65535)),
                   $urandom_range(99) < 12);
      end else if (r < 85) begin
        repeat ($urandom_range(5, 1)) send_byte(8'($urandom_range(255)));
      end else if (r < 93) begin
        send_byte(HDR_BYTE);
        if ($urandom_range(1)) begin
          send_byte(8'($urandom_range(255)));
        end else begin
          send_byte(HDR_BYTE);
          repeat ($urandom_range(5, 1)) send_byte(8'($urandom_range(255)));
        end
      end else if (r < 96) begin
        settle_input();
      end else begin
        send_frame(sb.held, pick_strength(), DIST_W'($urandom_range(65535)), 1'b0);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_reading({raw_distance_o, signal_strength_o, held_distance_o,
                        accepted_o, differs_o});
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (receiver_stalls && $urandom_range(99) < 20) begin
      stall_left = pick_gap();
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase;
    rst_ni          = 1'b0;
    in_valid_i      <= 1'b0;
    rx_byte_i       <= '0;
    out_ready_i     <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= REG_OFFSET;
    cfg_data_i      <= '0;
    bytes_sent      = 0;
    idle_cycles     = 0;
    stall_left      = 0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // second byte not a header, raw equal to held, out of window, bad checksum
    send_byte(HDR_BYTE);
    send_byte(8'h00);
    send_frame(16'h0000, 16'hFFFF, 16'h0000, 1'b0);
    send_frame(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
    send_frame(16'd100, 16'h1234, 16'hA55A, 1'b1);
    settle_input();

    phase = 0;
    while (bytes_sent < TOTAL_BYTES) begin
      case (phase)
        0: configure(0, 2, 4500);
        1: configure(-512, 0, 65535);
        2: configure(511, 0, 65535);
        3: configure(int'($urandom_range(1023)) - 512, 4500, 2);
        4: configure(0, 65535, 65535);
        5: configure(int'($urandom_range(1023)) - 512, 0, 0);
        6: configure(-512, 2, 4500);
        default: configure(int'($urandom_range(1023)) - 512, $urandom_range(5000),
                           $urandom_range(65535));
      endcase
      sender_gaps     = (phase % 3) != 1;
      receiver_stalls = (phase % 3) != 2;
      random_traffic(PHASE_BYTES);
      settle_input();
      phase++;
    end

    if (sb.mismatches == 0 && sb.expected_readings.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/lfpo_pkg.sv
sv/lfpo_sync.sv
sv/lfpo_filter.sv
sv/lidar_frame_parser_offset.sv
test/tb_top.sv
